// File: sv/tlf_pkg.sv
// Shared types, character codes and register indexes for the text line folder.
// No dependencies; every other file of the block imports this package.
package tlf_pkg;

    // Character codes the folder reacts to
    localparam logic [7:0] CH_NL    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    // Configuration port geometry and register indexes
    localparam int CFG_AW = 1;
    localparam int CFG_DW = 8;
    localparam logic [CFG_AW-1:0] REG_MAX_WIDTH    = 1'b0;
    localparam logic [CFG_AW-1:0] REG_BREAK_WINDOW = 1'b1;

    // Register values after reset
    localparam logic [7:0] MAX_WIDTH_RST    = 8'd80;
    localparam logic [3:0] BREAK_WINDOW_RST = 4'd10;

    typedef logic [7:0] char_t;

    // Per-cell controls of the holding row
    typedef struct packed {
        logic shift;   // take the neighbour's character
        logic load;    // take the incoming character
    } cell_ctrl_t;

    function automatic logic is_blank(input char_t c);
        return (c == CH_SPACE) || (c == CH_TAB);
    endfunction

endpackage

// File: sv/tlf_cell.sv
// One cell of the holding row: stores a character, shifts towards the head.
// Depends on tlf_pkg.
module tlf_cell (
    input  logic               aclk,
    input  tlf_pkg::cell_ctrl_t ctrl,
    input  tlf_pkg::char_t     load_ch,
    input  tlf_pkg::char_t     next_ch,
    output tlf_pkg::char_t     ch_q,
    output logic               blank
);
    import tlf_pkg::*;

    char_t ch_reg;
    char_t ch_next;

    // Load wins over shift so a dropped slot can be refilled in the same cycle
    always_comb begin
        ch_next = ch_reg;
        if (ctrl.load) begin
            ch_next = load_ch;
        end else if (ctrl.shift) begin
            ch_next = next_ch;
        end
    end

    always_ff @(posedge aclk) begin
        ch_reg <= ch_next;
    end

    assign ch_q  = ch_reg;
    assign blank = is_blank(ch_reg);

endmodule

// File: sv/text_line_folder_core.sv
// Greedy word-wrap line folder: top level with sequencer and holding row.
// Depends on tlf_pkg and tlf_cell.
//
// Usage:
//   Input words arrive on s_tdata (character) with s_tuser[0] as the flush
//   flag; folded output words leave on m_tdata with m_tlast marking the final
//   word produced by one input word. Configuration is a plain write port:
//   index 0 is the maximum line width, index 1 the break window.
//   An input word is taken while the sequencer is idle; the sequencer then
//   issues its output words while the receiver keeps up, and places the
//   character in the holding row. A plain character may issue no output word
//   or push held characters out of the row. Output words pass through the
//   single output register, and the holding row hands out one character per
//   cycle from its head while the receiver keeps up. m_tvalid is driven from
//   the output register and rises in the cycle after the sequencer step.
//   Reset empties the holding row, clears the column and restores width 80
//   and window 10. When the receiver stalls, the pending output word holds
//   and the sequencer waits; no new input word is taken until the current
//   one has issued all its output words.
module text_line_folder_core #(
    parameter int WINDOW = 10
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    // input stream
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [7:0]                 s_tdata,   // [7:0] ch
    input  logic [0:0]                 s_tuser,   // [0] flush
    // output stream
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [7:0]                 m_tdata,   // [7:0] out_ch
    output logic                       m_tlast,
    // configuration
    input  logic                       cfg_we,
    input  logic [tlf_pkg::CFG_AW-1:0] cfg_addr,
    input  logic [tlf_pkg::CFG_DW-1:0] cfg_wdata
);
    import tlf_pkg::*;

    localparam int CW  = $clog2(WINDOW + 1);
    localparam int CW1 = CW + 1;
    localparam int IW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;
    localparam int RW  = $clog2(WINDOW + 2);

    typedef enum logic [4:0] {
        ST_IDLE   = 5'b00001,
        ST_EMIT   = 5'b00010,
        ST_NL     = 5'b00100,
        ST_APPEND = 5'b01000,
        ST_TRIM   = 5'b10000
    } state_t;

    state_t        state_reg, state_next;
    logic [7:0]    max_width_reg, max_width_next;
    logic [3:0]    bw_reg, bw_next;
    logic [7:0]    col_reg, col_next;
    logic [CW-1:0] count_reg, count_next;
    logic [CW-1:0] emit_reg, emit_next;
    logic [RW-1:0] left_reg, left_next;
    logic          nl_reg, nl_next;
    logic          drop_reg, drop_next;
    logic          app_reg, app_next;
    logic          trim_reg, trim_next;
    char_t         ch_reg, ch_next;
    logic          m_valid_reg, m_valid_next;
    char_t         m_data_reg, m_data_next;
    logic          m_last_reg, m_last_next;

    char_t         cell_ch   [WINDOW];
    logic [WINDOW-1:0] cell_blank;
    cell_ctrl_t    cell_ctrl [WINDOW];

    logic          accept;
    logic          out_free;
    logic          out_ld;
    char_t         out_ch;
    logic          shift_all;
    logic          load_en;
    logic [CW-1:0] load_pos;
    logic [CW-1:0] keep;
    logic          found_any;
    logic [IW-1:0] found_j;
    logic [CW-1:0] found_k;
    logic [8:0]    col_plus;
    logic          over;
    logic          pre;
    logic [CW-1:0] after_cnt;
    logic [CW-1:0] trim_n;
    logic [CW-1:0] append_cnt;

    // Holding row, oldest character in cell 0
    generate
        for (genvar gi = 0; gi < WINDOW; gi++) begin : g_cell
            char_t nbr_ch;
            if (gi == WINDOW - 1) begin : g_tail
                assign nbr_ch = '0;
            end else begin : g_body
                assign nbr_ch = cell_ch[gi + 1];
            end
            assign cell_ctrl[gi].shift = shift_all;
            assign cell_ctrl[gi].load  = load_en && (load_pos == CW'(gi));
            tlf_cell u_cell (
                .aclk    (aclk),
                .ctrl    (cell_ctrl[gi]),
                .load_ch (ch_reg),
                .next_ch (nbr_ch),
                .ch_q    (cell_ch[gi]),
                .blank   (cell_blank[gi])
            );
        end
    endgenerate

    assign accept   = s_tvalid && s_tready;
    assign s_tready = (state_reg == ST_IDLE);
    assign out_free = !m_valid_reg || m_tready;

    // Clamp the window to 1..WINDOW; keep is how many characters stay held
    always_comb begin
        if (bw_reg == 4'd0) begin
            keep = '0;
        end else if (int'(bw_reg) > WINDOW) begin
            keep = CW'(WINDOW - 1);
        end else begin
            keep = CW'(bw_reg - 4'd1);
        end
    end

    // Search the held cells in reach of the window; the newest blank wins
    always_comb begin
        found_any = 1'b0;
        found_j   = '0;
        for (int i = 0; i < WINDOW; i++) begin
            if (cell_blank[i] && (CW'(i) < count_reg) &&
                (CW1'(i) + {1'b0, keep} >= {1'b0, count_reg})) begin
                found_any = 1'b1;
                found_j   = IW'(i);
            end
        end
    end

    assign found_k  = count_reg - CW'(found_j);
    assign col_plus = {1'b0, col_reg} + 9'd1;
    assign over     = col_plus > {1'b0, max_width_reg};

    // Plain character: make room if full, then trim down to the window
    assign pre       = (count_reg == CW'(WINDOW));
    assign after_cnt = count_reg - CW'(pre) + CW'(1);
    assign trim_n    = (after_cnt > keep) ? (after_cnt - keep) : '0;

    assign append_cnt = drop_reg ? count_reg : (count_reg + CW'(1));

    // Sequencer
    always_comb begin
        state_next     = state_reg;
        max_width_next = max_width_reg;
        bw_next        = bw_reg;
        col_next       = col_reg;
        count_next     = count_reg;
        emit_next      = emit_reg;
        left_next      = left_reg;
        nl_next        = nl_reg;
        drop_next      = drop_reg;
        app_next       = app_reg;
        trim_next      = trim_reg;
        ch_next        = ch_reg;
        out_ld         = 1'b0;
        out_ch         = cell_ch[0];
        shift_all      = 1'b0;
        load_en        = 1'b0;
        load_pos       = count_reg;

        // configuration writes
        if (cfg_we) begin
            case (cfg_addr)
                REG_MAX_WIDTH:    max_width_next = cfg_wdata[7:0];
                REG_BREAK_WINDOW: bw_next        = cfg_wdata[3:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (accept) begin
                    ch_next   = s_tdata;
                    nl_next   = 1'b0;
                    drop_next = 1'b0;
                    app_next  = 1'b0;
                    trim_next = 1'b0;
                    if (s_tuser[0]) begin
                        // flush: drain the row, column kept
                        emit_next = count_reg;
                        left_next = RW'(count_reg);
                    end else if (s_tdata == CH_NL || (over && is_blank(s_tdata))) begin
                        // newline in, or blank at the fold point
                        emit_next = count_reg;
                        nl_next   = 1'b1;
                        left_next = RW'(count_reg) + RW'(1);
                        col_next  = '0;
                    end else if (over && found_any) begin
                        // held blank turns into the newline
                        emit_next = CW'(found_j);
                        nl_next   = 1'b1;
                        drop_next = 1'b1;
                        app_next  = 1'b1;
                        left_next = RW'(found_j) + RW'(1);
                        col_next  = 8'(found_k);
                    end else if (over) begin
                        // hard break before the current character
                        emit_next = count_reg;
                        nl_next   = 1'b1;
                        app_next  = 1'b1;
                        left_next = RW'(count_reg) + RW'(1);
                        col_next  = 8'd1;
                    end else begin
                        emit_next = CW'(pre);
                        app_next  = 1'b1;
                        trim_next = 1'b1;
                        left_next = RW'(pre) + RW'(trim_n);
                        col_next  = col_plus[7:0];
                    end
                    if (emit_next != '0) begin
                        state_next = ST_EMIT;
                    end else if (nl_next) begin
                        state_next = ST_NL;
                    end else if (app_next) begin
                        state_next = ST_APPEND;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_EMIT: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    shift_all  = 1'b1;
                    count_next = count_reg - CW'(1);
                    emit_next  = emit_reg - CW'(1);
                    if (emit_reg == CW'(1)) begin
                        if (nl_reg) begin
                            state_next = ST_NL;
                        end else if (app_reg) begin
                            state_next = ST_APPEND;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                end
            end
            ST_NL: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    out_ch     = CH_NL;
                    state_next = app_reg ? ST_APPEND : ST_IDLE;
                end
            end
            ST_APPEND: begin
                // drop the blank at the head while placing the character
                load_en    = 1'b1;
                shift_all  = drop_reg;
                load_pos   = drop_reg ? (count_reg - CW'(1)) : count_reg;
                count_next = append_cnt;
                state_next = (trim_reg && append_cnt > keep) ? ST_TRIM : ST_IDLE;
            end
            ST_TRIM: begin
                if (out_free) begin
                    out_ld     = 1'b1;
                    shift_all  = 1'b1;
                    count_next = count_reg - CW'(1);
                    if (count_reg - CW'(1) <= keep) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase

        // output register
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        m_last_next  = m_last_reg;
        if (out_ld) begin
            m_valid_next = 1'b1;
            m_data_next  = out_ch;
            m_last_next  = (left_reg == RW'(1));
            left_next    = left_reg - RW'(1);
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            max_width_reg <= MAX_WIDTH_RST;
            bw_reg        <= BREAK_WINDOW_RST;
            col_reg       <= '0;
            count_reg     <= '0;
            emit_reg      <= '0;
            left_reg      <= '0;
            nl_reg        <= 1'b0;
            drop_reg      <= 1'b0;
            app_reg       <= 1'b0;
            trim_reg      <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            max_width_reg <= max_width_next;
            bw_reg        <= bw_next;
            col_reg       <= col_next;
            count_reg     <= count_next;
            emit_reg      <= emit_next;
            left_reg      <= left_next;
            nl_reg        <= nl_next;
            drop_reg      <= drop_next;
            app_reg       <= app_next;
            trim_reg      <= trim_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        ch_reg     <= ch_next;
        m_data_reg <= m_data_next;
        m_last_reg <= m_last_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;
    assign m_tlast  = m_last_reg;

    // The row never holds more than it has cells
    assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= CW'(WINDOW))
        else $error("holding row overfilled");

    // Every announced output word is issued before the next input word
    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |-> (left_reg == '0))
        else $error("output words outstanding while idle");

    // After the word marked last, no more output words for this item
    assert property (@(posedge aclk) disable iff (!aresetn)
        (out_ld && left_reg == RW'(1)) |=>
            !(state_reg == ST_EMIT || state_reg == ST_NL || state_reg == ST_TRIM))
        else $error("output word issued after last");

endmodule
